FILE: rtl/kvcs_pkg.sv
package kvcs_pkg;

   // Row limit of the cache; capacity is used as min(capacity, ROW_LIMIT)
   localparam logic [12:0] ROW_LIMIT = 13'd4096;

   // Configuration register indexes
   localparam logic CSR_CAPACITY    = 1'b0;
   localparam logic CSR_LAYER_COUNT = 1'b1;

   // Reset values of the configuration registers
   localparam logic [12:0] CAPACITY_RESET    = 13'd4096;
   localparam logic [6:0]  LAYER_COUNT_RESET = 7'd64;

   typedef enum logic [2:0] {
      CMD_CLEAR          = 3'd0,
      CMD_PREFILL_WRITE  = 3'd1,
      CMD_DECODE_WRITE   = 3'd2,
      CMD_DECODE_RECORD  = 3'd3,
      CMD_PREFILL_COMMIT = 3'd4,
      CMD_PREFILL_ABORT  = 3'd5,
      CMD_DECODE_COMMIT  = 3'd6,
      CMD_DECODE_ABORT   = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_LAYER  = 3'd1,
      ST_ORDER      = 3'd2,
      ST_RANGE      = 3'd3,
      ST_CHANGED    = 3'd4,
      ST_SHAPE      = 3'd5,
      ST_TWICE      = 3'd6,
      ST_INCOMPLETE = 3'd7
   } status_type;

   // Transaction state apart from the layer bitmap
   typedef struct packed {
      logic [12:0] length;
      logic [12:0] pending;
      logic        prefill_open;
      logic        decode_open;
   } txn_state_type;

   // Per-command copy decision
   typedef struct packed {
      status_type  status;
      logic        copy_enable;
      logic [11:0] write_row;
      logic [12:0] row_count;
   } result_type;

endpackage

FILE: rtl/kvcs_check.sv
module kvcs_check
   import kvcs_pkg::*;
#(
   parameter int MAX_LAYERS = 64
) (
   input  logic [2:0]            cmd,
   input  logic [5:0]            layer,
   input  logic [12:0]           amount,
   input  logic                  shape_ok,
   input  logic [12:0]           capacity,
   input  logic [6:0]            layer_count,
   input  txn_state_type         cur_state,
   input  logic [MAX_LAYERS-1:0] cur_layers,
   output result_type            result,
   output txn_state_type         nxt_state,
   output logic [MAX_LAYERS-1:0] nxt_layers
);

   logic [12:0]           eff_cap;
   logic [6:0]            eff_layers;
   logic [MAX_LAYERS-1:0] layer_bit;
   logic [MAX_LAYERS-1:0] need_mask;
   logic                  bad_layer;
   logic                  layer_seen;
   logic                  all_written;

   // Effective limits
   assign eff_cap    = (capacity < ROW_LIMIT) ? capacity : ROW_LIMIT;
   assign eff_layers = (layer_count < 7'(MAX_LAYERS)) ? layer_count : 7'(MAX_LAYERS);
   assign bad_layer  = {1'b0, layer} >= eff_layers;

   // One-hot layer select and mask of layers required for commit
   always_comb begin
      for (int i = 0; i < MAX_LAYERS; i++) begin
         layer_bit[i] = ({1'b0, layer} == 7'(i));
         need_mask[i] = (7'(i) < eff_layers);
      end
   end

   assign layer_seen  = |(cur_layers & layer_bit);
   assign all_written = ((cur_layers & need_mask) == need_mask);

   // Command checks in priority order; failing commands keep the state
   always_comb begin
      result.status      = ST_OK;
      result.copy_enable = 1'b0;
      result.write_row   = 12'd0;
      result.row_count   = 13'd0;
      nxt_state          = cur_state;
      nxt_layers         = cur_layers;
      case (cmd_type'(cmd))
         CMD_CLEAR: begin
            nxt_state  = '0;
            nxt_layers = '0;
         end
         CMD_PREFILL_WRITE: begin
            if (bad_layer) result.status = ST_BAD_LAYER;
            else if (cur_state.length != 13'd0 || cur_state.decode_open)
               result.status = ST_ORDER;
            else if (amount == 13'd0 || amount > eff_cap) result.status = ST_RANGE;
            else if (cur_state.prefill_open && cur_state.pending != amount)
               result.status = ST_CHANGED;
            else if (!shape_ok) result.status = ST_SHAPE;
            else if (layer_seen) result.status = ST_TWICE;
            else begin
               nxt_state.prefill_open = 1'b1;
               nxt_state.pending      = amount;
               nxt_layers             = cur_layers | layer_bit;
               result.copy_enable     = 1'b1;
               result.row_count       = amount;
            end
         end
         CMD_DECODE_WRITE, CMD_DECODE_RECORD: begin
            if (bad_layer) result.status = ST_BAD_LAYER;
            else if (cur_state.length == 13'd0 || cur_state.prefill_open)
               result.status = ST_ORDER;
            else if (amount != cur_state.length || amount >= eff_cap)
               result.status = ST_RANGE;
            else if (cmd_type'(cmd) == CMD_DECODE_WRITE && !shape_ok)
               result.status = ST_SHAPE;
            else if (cur_state.decode_open && cur_state.pending != amount)
               result.status = ST_CHANGED;
            else if (layer_seen) result.status = ST_TWICE;
            else begin
               nxt_state.decode_open = 1'b1;
               nxt_state.pending     = amount;
               nxt_layers            = cur_layers | layer_bit;
               if (cmd_type'(cmd) == CMD_DECODE_WRITE) begin
                  result.copy_enable = 1'b1;
                  result.write_row   = amount[11:0];
                  result.row_count   = 13'd1;
               end
            end
         end
         CMD_PREFILL_COMMIT: begin
            if (!cur_state.prefill_open || cur_state.decode_open) result.status = ST_ORDER;
            else if (amount == 13'd0 || amount > eff_cap) result.status = ST_RANGE;
            else if (cur_state.pending != amount) result.status = ST_CHANGED;
            else if (!all_written) result.status = ST_INCOMPLETE;
            else begin
               nxt_state.length       = amount;
               nxt_state.prefill_open = 1'b0;
               nxt_state.pending      = 13'd0;
               nxt_layers             = '0;
            end
         end
         CMD_PREFILL_ABORT: begin
            if (cur_state.decode_open) result.status = ST_ORDER;
            else begin
               nxt_state.prefill_open = 1'b0;
               nxt_state.pending      = 13'd0;
               nxt_layers             = '0;
            end
         end
         CMD_DECODE_COMMIT: begin
            if (!cur_state.decode_open || cur_state.prefill_open) result.status = ST_ORDER;
            else if (amount != cur_state.length || amount >= eff_cap)
               result.status = ST_RANGE;
            else if (!all_written) result.status = ST_INCOMPLETE;
            else begin
               nxt_state.length      = cur_state.length + 13'd1;
               nxt_state.decode_open = 1'b0;
               nxt_state.pending     = 13'd0;
               nxt_layers            = '0;
            end
         end
         default: begin
            // abort decode
            if (cur_state.prefill_open) result.status = ST_ORDER;
            else begin
               nxt_state.decode_open = 1'b0;
               nxt_state.pending     = 13'd0;
               nxt_layers            = '0;
            end
         end
      endcase
   end

endmodule

FILE: rtl/kv_cache_commit_sequencer_core.sv
// Channel  Direction  Handshake        Payload
// req      in         req_valid/stall  cmd, layer, amount, shape_ok
// rsp      out        rsp_valid/stall  status, copy_enable, write_row, row_count,
//                                      cache_length, prefill_pending, decode_pending
// csr      in         csr_write_enable csr_index, csr_write_data
//
// One item per cycle sustained while rsp_stall is low; an item passes the input
// register, then checks and state update into the result register, and rsp_valid
// rises once it is in the result register.
// Synchronous active-high reset clears the transaction state and loads the
// register defaults. A stalled result holds the result register; the input
// register still takes one more item, then req_stall rises until rsp moves.
module kv_cache_commit_sequencer_core
   import kvcs_pkg::*;
#(
   parameter int MAX_LAYERS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [5:0]  req_layer,
   input  logic [12:0] req_amount,
   input  logic        req_shape_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_copy_enable,
   output logic [11:0] rsp_write_row,
   output logic [12:0] rsp_row_count,
   output logic [12:0] rsp_cache_length,
   output logic        rsp_prefill_pending,
   output logic        rsp_decode_pending,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [12:0] csr_write_data
);

   logic [12:0]           capacity_ff;
   logic [6:0]            layer_count_ff;
   logic                  s1_valid_ff;
   logic [2:0]            s1_cmd_ff;
   logic [5:0]            s1_layer_ff;
   logic [12:0]           s1_amount_ff;
   logic                  s1_shape_ok_ff;
   txn_state_type         state_ff;
   txn_state_type         state_in;
   logic [MAX_LAYERS-1:0] layers_ff;
   logic [MAX_LAYERS-1:0] layers_in;
   result_type            result_in;
   result_type            result_ff;
   logic                  out_valid_ff;
   logic                  advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= CAPACITY_RESET;
         layer_count_ff <= LAYER_COUNT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_CAPACITY) capacity_ff <= csr_write_data;
         else layer_count_ff <= csr_write_data[6:0];
      end
   end

   // Pipeline flow
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_cmd_ff      <= req_cmd;
         s1_layer_ff    <= req_layer;
         s1_amount_ff   <= req_amount;
         s1_shape_ok_ff <= req_shape_ok;
      end
   end

   // Command checks and next state
   kvcs_check #(
      .MAX_LAYERS(MAX_LAYERS)
   ) u_check (
      .cmd        (s1_cmd_ff),
      .layer      (s1_layer_ff),
      .amount     (s1_amount_ff),
      .shape_ok   (s1_shape_ok_ff),
      .capacity   (capacity_ff),
      .layer_count(layer_count_ff),
      .cur_state  (state_ff),
      .cur_layers (layers_ff),
      .result     (result_in),
      .nxt_state  (state_in),
      .nxt_layers (layers_in)
   );

   // Transaction state, updated when an item moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         layers_ff <= '0;
      end else if (s1_valid_ff && advance) begin
         state_ff  <= state_in;
         layers_ff <= layers_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = result_ff.status;
   assign rsp_copy_enable     = result_ff.copy_enable;
   assign rsp_write_row       = result_ff.write_row;
   assign rsp_row_count       = result_ff.row_count;
   assign rsp_cache_length    = state_ff.length;
   assign rsp_prefill_pending = state_ff.prefill_open;
   assign rsp_decode_pending  = state_ff.decode_open;

endmodule

FILE: tb/tb_kv_cache_commit_sequencer_core.sv
`timescale 1ns / 1ps

module tb_kv_cache_commit_sequencer_core;
   import kvcs_pkg::*;

   localparam logic [6:0]  LAYER_LIMIT    = 7'd64;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned IDLE_HEAVY     = 52;
   localparam int unsigned IDLE_BOTH      = 23;
   localparam int          OPENING_ROWS   = 35;

   // Expected outcome of one command
   typedef struct packed {
      status_type  status;
      logic        copy_enable;
      logic [11:0] write_row;
      logic [12:0] row_count;
      logic [12:0] cache_length;
      logic        prefill_pending;
      logic        decode_pending;
   } cmd_verdict_type;

   // One step of the opening sequence: a register write or a command
   typedef struct packed {
      logic        is_csr;
      logic        csr_sel;
      logic [12:0] csr_data;
      cmd_type     cmd;
      logic [5:0]  layer;
      logic [12:0] amount;
      logic        shape_ok;
      logic        typed;
      status_type  want;
   } opening_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = CMD_CLEAR;
   logic [5:0]  req_layer = 6'd0;
   logic [12:0] req_amount = 13'd0;
   logic        req_shape_ok = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_copy_enable;
   logic [11:0] rsp_write_row;
   logic [12:0] rsp_row_count;
   logic [12:0] rsp_cache_length;
   logic        rsp_prefill_pending;
   logic        rsp_decode_pending;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_CAPACITY;
   logic [12:0] csr_write_data = 13'd0;

   // Shadow of the block: registers and transaction state
   logic [12:0] cfg_capacity = CAPACITY_RESET;
   logic [6:0]  cfg_layers = LAYER_COUNT_RESET;
   logic [12:0] cached_length = 13'd0;
   logic [12:0] open_amount = 13'd0;
   logic        prefill_active = 1'b0;
   logic        decode_active = 1'b0;
   logic [63:0] layer_map = 64'd0;

   cmd_verdict_type verdict_q [$];
   cmd_verdict_type want_now;
   int unsigned     layer_order [64];
   int unsigned     items_sent = 0;
   int unsigned     error_count = 0;
   int unsigned     idle_cycles = 0;
   int unsigned     send_gap_pct = 0;
   int unsigned     stall_pct = 0;
   int              k;

   // Directed opening: errors typed in, good commands left to the predictor
   opening_step_type opening_steps [0:OPENING_ROWS-1] = '{
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_DECODE_COMMIT, 6'd0, 13'd0, 1'b1, 1'b1, ST_ORDER},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_DECODE_RECORD, 6'd0, 13'd0, 1'b1, 1'b1, ST_ORDER},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_WRITE, 6'd63, 13'd0, 1'b1, 1'b1, ST_RANGE},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_WRITE, 6'd63, 13'd8191, 1'b1, 1'b1, ST_RANGE},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_WRITE, 6'd63, 13'd4096, 1'b0, 1'b1, ST_SHAPE},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_WRITE, 6'd63, 13'd4096, 1'b1, 1'b0, ST_OK},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_WRITE, 6'd63, 13'd4096, 1'b1, 1'b1, ST_TWICE},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_WRITE, 6'd0, 13'd5, 1'b1, 1'b1, ST_CHANGED},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_COMMIT, 6'd0, 13'd4096, 1'b1, 1'b1,
        ST_INCOMPLETE},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_DECODE_ABORT, 6'd0, 13'd0, 1'b1, 1'b1, ST_ORDER},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_ABORT, 6'd0, 13'd0, 1'b1, 1'b0, ST_OK},
      // abort with nothing open
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_ABORT, 6'd0, 13'd0, 1'b0, 1'b0, ST_OK},
      '{1'b1, CSR_LAYER_COUNT, 13'd2, CMD_CLEAR, 6'd0, 13'd0, 1'b0, 1'b0, ST_OK},
      '{1'b1, CSR_CAPACITY, 13'd4, CMD_CLEAR, 6'd0, 13'd0, 1'b0, 1'b0, ST_OK},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_WRITE, 6'd2, 13'd3, 1'b1, 1'b1, ST_BAD_LAYER},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_WRITE, 6'd0, 13'd3, 1'b1, 1'b0, ST_OK},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_COMMIT, 6'd0, 13'd2, 1'b1, 1'b1, ST_CHANGED},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_COMMIT, 6'd0, 13'd3, 1'b1, 1'b1,
        ST_INCOMPLETE},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_WRITE, 6'd1, 13'd3, 1'b1, 1'b0, ST_OK},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_COMMIT, 6'd0, 13'd3, 1'b1, 1'b0, ST_OK},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_DECODE_WRITE, 6'd0, 13'd2, 1'b1, 1'b1, ST_RANGE},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_DECODE_WRITE, 6'd0, 13'd3, 1'b0, 1'b1, ST_SHAPE},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_DECODE_RECORD, 6'd0, 13'd3, 1'b1, 1'b0, ST_OK},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_DECODE_WRITE, 6'd1, 13'd3, 1'b1, 1'b0, ST_OK},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_DECODE_COMMIT, 6'd0, 13'd3, 1'b1, 1'b0, ST_OK},
      // record index at capacity
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_DECODE_RECORD, 6'd0, 13'd4, 1'b1, 1'b1, ST_RANGE},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_CLEAR, 6'd0, 13'd0, 1'b1, 1'b1, ST_OK},
      // zero capacity
      '{1'b1, CSR_CAPACITY, 13'd0, CMD_CLEAR, 6'd0, 13'd0, 1'b0, 1'b0, ST_OK},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_WRITE, 6'd0, 13'd1, 1'b1, 1'b1, ST_RANGE},
      '{1'b1, CSR_CAPACITY, 13'd8191, CMD_CLEAR, 6'd0, 13'd0, 1'b0, 1'b0, ST_OK},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_WRITE, 6'd0, 13'd4096, 1'b1, 1'b0, ST_OK},
      // zero layer count: writes fail, an open prefill still commits
      '{1'b1, CSR_LAYER_COUNT, 13'd0, CMD_CLEAR, 6'd0, 13'd0, 1'b0, 1'b0, ST_OK},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_DECODE_RECORD, 6'd0, 13'd0, 1'b1, 1'b1, ST_BAD_LAYER},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_PREFILL_COMMIT, 6'd0, 13'd4096, 1'b1, 1'b0, ST_OK},
      '{1'b0, CSR_CAPACITY, 13'd0, CMD_DECODE_ABORT, 6'd0, 13'd0, 1'b1, 1'b0, ST_OK}
   };

   kv_cache_commit_sequencer_core #(
      .MAX_LAYERS(64)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_layer(req_layer),
      .req_amount(req_amount),
      .req_shape_ok(req_shape_ok),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_copy_enable(rsp_copy_enable),
      .rsp_write_row(rsp_write_row),
      .rsp_row_count(rsp_row_count),
      .rsp_cache_length(rsp_cache_length),
      .rsp_prefill_pending(rsp_prefill_pending),
      .rsp_decode_pending(rsp_decode_pending),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [12:0] row_limit_now();
      return (cfg_capacity > ROW_LIMIT) ? ROW_LIMIT : cfg_capacity;
   endfunction

   function automatic logic [6:0] layer_limit_now();
      return (cfg_layers > LAYER_LIMIT) ? LAYER_LIMIT : cfg_layers;
   endfunction

   // Apply one command to the shadow state and return what the block must report
   function automatic cmd_verdict_type judge_command(cmd_type c, logic [5:0] lay,
                                                     logic [12:0] amt, logic shp);
      cmd_verdict_type v;
      logic [12:0]     cap;
      logic [6:0]      nlay;
      logic [63:0]     need;
      logic            full;
      logic            bad_layer;
      v = '0;
      cap = row_limit_now();
      nlay = layer_limit_now();
      need = (nlay >= LAYER_LIMIT) ? '1 : ((64'd1 << nlay) - 64'd1);
      full = ((layer_map & need) == need);
      bad_layer = ({1'b0, lay} >= nlay);
      v.status = ST_OK;
      case (c)
         CMD_CLEAR: begin
            cached_length = 13'd0;
            open_amount = 13'd0;
            prefill_active = 1'b0;
            decode_active = 1'b0;
            layer_map = 64'd0;
         end
         CMD_PREFILL_WRITE: begin
            if (bad_layer) v.status = ST_BAD_LAYER;
            else if (cached_length != 13'd0 || decode_active) v.status = ST_ORDER;
            else if (amt == 13'd0 || amt > cap) v.status = ST_RANGE;
            else if (prefill_active && open_amount != amt) v.status = ST_CHANGED;
            else if (!shp) v.status = ST_SHAPE;
            else if (layer_map[lay]) v.status = ST_TWICE;
            else begin
               prefill_active = 1'b1;
               open_amount = amt;
               layer_map[lay] = 1'b1;
               v.copy_enable = 1'b1;
               v.row_count = amt;
            end
         end
         CMD_DECODE_WRITE, CMD_DECODE_RECORD: begin
            // decode write checks shape before a changed index
            if (bad_layer) v.status = ST_BAD_LAYER;
            else if (cached_length == 13'd0 || prefill_active) v.status = ST_ORDER;
            else if (amt != cached_length || amt >= cap) v.status = ST_RANGE;
            else if (c == CMD_DECODE_WRITE && !shp) v.status = ST_SHAPE;
            else if (decode_active && open_amount != amt) v.status = ST_CHANGED;
            else if (layer_map[lay]) v.status = ST_TWICE;
            else begin
               decode_active = 1'b1;
               open_amount = amt;
               layer_map[lay] = 1'b1;
               if (c == CMD_DECODE_WRITE) begin
                  v.copy_enable = 1'b1;
                  v.write_row = amt[11:0];
                  v.row_count = 13'd1;
               end
            end
         end
         CMD_PREFILL_COMMIT: begin
            if (!prefill_active || decode_active) v.status = ST_ORDER;
            else if (amt == 13'd0 || amt > cap) v.status = ST_RANGE;
            else if (open_amount != amt) v.status = ST_CHANGED;
            else if (!full) v.status = ST_INCOMPLETE;
            else begin
               cached_length = amt;
               prefill_active = 1'b0;
               open_amount = 13'd0;
               layer_map = 64'd0;
            end
         end
         CMD_PREFILL_ABORT: begin
            if (decode_active) v.status = ST_ORDER;
            else begin
               prefill_active = 1'b0;
               open_amount = 13'd0;
               layer_map = 64'd0;
            end
         end
         CMD_DECODE_COMMIT: begin
            if (!decode_active || prefill_active) v.status = ST_ORDER;
            else if (amt != cached_length || amt >= cap) v.status = ST_RANGE;
            else if (!full) v.status = ST_INCOMPLETE;
            else begin
               cached_length = cached_length + 13'd1;
               decode_active = 1'b0;
               open_amount = 13'd0;
               layer_map = 64'd0;
            end
         end
         default: begin
            if (prefill_active) v.status = ST_ORDER;
            else begin
               decode_active = 1'b0;
               open_amount = 13'd0;
               layer_map = 64'd0;
            end
         end
      endcase
      v.cache_length = cached_length;
      v.prefill_pending = prefill_active;
      v.decode_pending = decode_active;
      return v;
   endfunction

   // Present one item, hold it until accepted, then record its outcome
   task automatic send_item(cmd_type c, logic [5:0] lay, logic [12:0] amt, logic shp,
                            logic typed, status_type fixed);
      cmd_verdict_type v;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_layer <= lay;
      req_amount <= amt;
      req_shape_ok <= shp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      v = judge_command(c, lay, amt, shp);
      if (typed) v.status = fixed;
      verdict_q.push_back(v);
      items_sent++;
   endtask

   task automatic issue(cmd_type c, logic [5:0] lay, logic [12:0] amt, logic shp);
      send_item(c, lay, amt, shp, 1'b0, ST_OK);
   endtask

   // Drop valid and wait until every result is back and the pipeline is empty
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic sel, logic [12:0] data);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= sel;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (sel == CSR_CAPACITY) cfg_capacity = data;
      else cfg_layers = data[6:0];
   endtask

   task automatic shuffle_layer_order(int unsigned n);
      int unsigned i;
      int unsigned j;
      int unsigned tmp;
      for (i = 0; i < 64; i++) layer_order[i] = i;
      for (i = n; i > 1; i--) begin
         j = $urandom_range(0, i - 1);
         tmp = layer_order[i - 1];
         layer_order[i - 1] = layer_order[j];
         layer_order[j] = tmp;
      end
   endtask

   // A prefill (empty cache) or decode step over all layers, then commit or abort
   task automatic run_transaction();
      int unsigned n;
      int unsigned i;
      int unsigned flaw;
      int unsigned lim;
      logic [12:0] amt;
      logic [12:0] a;
      logic [5:0]  lay;
      logic        shp;
      logic        decoding;
      cmd_type     c;
      decoding = (cached_length != 13'd0);
      n = 32'(layer_limit_now());
      if (decoding) amt = cached_length;
      else begin
         lim = 32'(row_limit_now());
         if (lim > 16) lim = 16;
         if (lim == 0) lim = 1;
         flaw = $urandom_range(0, 99);
         if (flaw < 70) amt = 13'($urandom_range(1, lim));
         else if (flaw < 85) amt = row_limit_now();
         else amt = 13'($urandom_range(0, 8191));
      end
      shuffle_layer_order(n);
      for (i = 0; i < n; i++) begin
         lay = 6'(layer_order[i]);
         a = amt;
         shp = 1'b1;
         if (!decoding) c = CMD_PREFILL_WRITE;
         else c = $urandom_range(0, 1) ? CMD_DECODE_WRITE : CMD_DECODE_RECORD;
         // occasional broken step
         flaw = $urandom_range(0, 99);
         if (flaw < 3) shp = 1'b0;
         else if (flaw < 5) a = $urandom_range(0, 1) ? amt + 13'd1 : amt - 13'd1;
         else if (flaw < 7) lay = 6'($urandom_range(0, 63));
         issue(c, lay, a, shp);
      end
      flaw = $urandom_range(0, 99);
      lay = 6'($urandom_range(0, 63));
      shp = 1'($urandom_range(0, 1));
      if (flaw < 5) begin
         issue(decoding ? CMD_DECODE_ABORT : CMD_PREFILL_ABORT, lay,
               13'($urandom_range(0, 8191)), shp);
      end else begin
         a = (flaw < 10) ? 13'($urandom_range(0, 8191)) : amt;
         issue(decoding ? CMD_DECODE_COMMIT : CMD_PREFILL_COMMIT, lay, a, shp);
      end
   endtask

   // Set the registers and the idling pattern, then run mostly well-formed traffic
   task automatic run_phase(logic [12:0] cap, logic [12:0] layers, int unsigned gap,
                            int unsigned stall, int unsigned quota);
      int unsigned stop_at;
      int unsigned pick;
      write_csr(CSR_CAPACITY, cap);
      write_csr(CSR_LAYER_COUNT, layers);
      send_gap_pct = gap;
      stall_pct = stall;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            issue(cmd_type'(3'($urandom_range(0, 7))), 6'($urandom_range(0, 63)),
                  13'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)));
         end else if (pick < 11 ||
                      (cached_length != 0 && cached_length >= row_limit_now() && pick < 50)) begin
            issue(CMD_CLEAR, 6'($urandom_range(0, 63)), 13'($urandom_range(0, 8191)),
                  1'($urandom_range(0, 1)));
         end else if (pick < 15) begin
            issue(pick[0] ? CMD_PREFILL_ABORT : CMD_DECODE_ABORT, 6'($urandom_range(0, 63)),
                  13'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)));
         end else begin
            run_transaction();
         end
      end
   endtask

   task automatic check_field(string label, logic [12:0] exp_v, logic [12:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s expected %0d got %0d", $time, label, exp_v, got_v);
         error_count++;
      end
   endtask

   // Receiver stalls
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: result with no command waiting, status %0d length %0d",
                     $time, rsp_status, rsp_cache_length);
            error_count++;
         end else begin
            want_now = verdict_q.pop_front();
            check_field("status", 13'(want_now.status), 13'(rsp_status));
            check_field("copy_enable", 13'(want_now.copy_enable), 13'(rsp_copy_enable));
            check_field("write_row", 13'(want_now.write_row), 13'(rsp_write_row));
            check_field("row_count", want_now.row_count, rsp_row_count);
            check_field("cache_length", want_now.cache_length, rsp_cache_length);
            check_field("prefill_pending", 13'(want_now.prefill_pending),
                        13'(rsp_prefill_pending));
            check_field("decode_pending", 13'(want_now.decode_pending),
                        13'(rsp_decode_pending));
         end
      end
   end

   // Watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening, starting at reset register values, no idling
      for (k = 0; k < OPENING_ROWS; k++) begin
         if (opening_steps[k].is_csr) begin
            write_csr(opening_steps[k].csr_sel, opening_steps[k].csr_data);
         end else begin
            send_item(opening_steps[k].cmd, opening_steps[k].layer, opening_steps[k].amount,
                      opening_steps[k].shape_ok, opening_steps[k].typed,
                      opening_steps[k].want);
         end
      end

      // random phases over register settings and idling patterns
      run_phase(13'd4096, 13'd4, 0, 0, 200);
      run_phase(13'd8191, 13'd64, IDLE_HEAVY, 0, 170);
      run_phase(13'd6, 13'd3, 0, IDLE_HEAVY, 180);
      run_phase(13'd1, 13'd1, IDLE_BOTH, IDLE_BOTH, 150);
      run_phase(13'd0, 13'd0, 0, 0, 60);
      run_phase(13'd100, 13'd127, IDLE_BOTH, IDLE_BOTH, 160);
      run_phase(13'd2000, 13'd8, IDLE_HEAVY, 0, 180);

      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
